// ===== sv/binary_max_heap_queue_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the binary max-heap priority queue.
// ---------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// Checked on every rising edge while reset is low.
`define BMHQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BMHQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bmhq_pkg.sv =====
// ---------------------------------------------------------------------------
// bmhq_pkg
// Types and constants shared by the priority queue top level and its cells.
// ---------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_t;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    action_t action;
    key_t    key_in;
  } in_beat_t;

  typedef struct packed {
    key_t               popped_key;
    logic               pop_ok;
    key_t               top_key;
    logic               not_empty;
    logic [COUNT_W-1:0] entry_count;
    logic               insert_rejected;
  } out_beat_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
    key_t key;
  } cell_ctrl_t;

endpackage

// ===== sv/bmhq_cell.sv =====
// ---------------------------------------------------------------------------
// bmhq_cell
// One slot of the sorted key row. Keys sit in descending order from cell 0;
// an insert shifts the smaller keys one place down, a pop shifts all up.
// ---------------------------------------------------------------------------
module bmhq_cell (
  input  logic                clk,
  input  bmhq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  bmhq_pkg::key_t      prev_key,
  input  logic                prev_gt,
  input  bmhq_pkg::key_t      next_key,
  output bmhq_pkg::key_t      key,
  output logic                gt
);

  bmhq_pkg::key_t key_q;
  bmhq_pkg::key_t key_next;

  // An empty slot behaves as if it held a key below every other key.
  assign gt  = !occ || (ctrl.key > key_q);
  assign key = key_q;

  always_comb begin
    key_next = key_q;
    if (ctrl.ins && gt) begin
      // The first cell where the new key wins takes it; later ones shift.
      key_next = prev_gt ? prev_key : ctrl.key;
    end else if (ctrl.pop) begin
      key_next = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
  end

endmodule

// ===== sv/binary_max_heap_queue.sv =====
// ---------------------------------------------------------------------------
// binary_max_heap_queue
// Priority queue of signed 32-bit keys that always hands out the largest.
//
// Input channel (in_valid/in_ready/in_data) carries one request per beat:
// insert key_in, or pop the largest key. Output channel (out_valid/out_ready/
// out_data) returns exactly one result beat per request: the popped key, the
// new top key, the entry count and the not_empty/pop_ok/insert_rejected flags.
// Keys live in a row of CAPACITY cells kept in descending order; every cell
// updates from its neighbors in the same cycle, and the result beat appears
// the cycle after the request is accepted. The block sustains one request
// per cycle while each beat is taken, set by the single result register.
// While the receiver stalls, the result register holds its beat and in_ready
// stays low until that beat is taken; a taken beat frees the register in the
// same cycle, so a new request can be accepted then.
// Reset empties the queue and clears out_valid; cell contents are left as
// they are and only the entries below the count are ever used.
// A pop on an empty queue reports pop_ok low; an insert into a full queue
// reports insert_rejected and drops the key.
// ---------------------------------------------------------------------------
`include "binary_max_heap_queue_defines.svh"

module binary_max_heap_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmhq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmhq_pkg::out_beat_t out_data
);

  localparam int CAPACITY = bmhq_pkg::CAPACITY;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCW      = bmhq_pkg::COUNT_W;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 in_fire;
  logic                 full;
  logic                 empty;
  bmhq_pkg::cell_ctrl_t ctrl;
  bmhq_pkg::key_t       cell_key [CAPACITY];
  logic                 cell_gt  [CAPACITY];
  bmhq_pkg::out_beat_t  res;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  assign ctrl.ins = in_fire && (in_data.action == bmhq_pkg::ACT_INSERT) && !full;
  assign ctrl.pop = in_fire && (in_data.action == bmhq_pkg::ACT_POP) && !empty;
  assign ctrl.key = in_data.key_in;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bmhq_pkg::key_t prev_key;
    logic           prev_gt;
    bmhq_pkg::key_t next_key;

    if (i == 0) begin : g_head
      assign prev_key = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = cell_key[i];
    end else begin : g_link
      assign next_key = cell_key[i+1];
    end

    bmhq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (CNT_W'(i) < count),
      .prev_key (prev_key),
      .prev_gt  (prev_gt),
      .next_key (next_key),
      .key      (cell_key[i]),
      .gt       (cell_gt[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end

    res                 = '0;
    res.pop_ok          = ctrl.pop;
    res.popped_key      = ctrl.pop ? cell_key[0] : '0;
    res.insert_rejected = in_fire && (in_data.action == bmhq_pkg::ACT_INSERT) && full;
    res.not_empty       = (count_next != '0);
    res.entry_count     = OCW'(count_next);
    if (ctrl.ins) begin
      res.top_key = cell_gt[0] ? ctrl.key : cell_key[0];
    end else if (ctrl.pop) begin
      res.top_key = (count > CNT_W'(1)) ? cell_key[1] : '0;
    end else begin
      res.top_key = empty ? '0 : cell_key[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res;
    end
  end

  `BMHQ_ASSERT(a_insert_count, (ctrl.ins |=> count == $past(count) + 1'b1), "count not grown")
  `BMHQ_ASSERT(a_head_sorted, ((count > CNT_W'(1)) |-> cell_key[0] >= cell_key[1]), "head unsorted")
  `BMHQ_ASSERT(a_result_follows, (in_fire |=> out_valid), "request produced no result beat")
  `BMHQ_ASSERT(a_count_bound, (count <= CNT_W'(CAPACITY)), "entry count beyond capacity")
  `BMHQ_ASSERT_ALWAYS(a_reset_clears, (rst |=> !out_valid), "result beat left after reset")

endmodule
